@@ hw/rtl/sptc_pkg.sv @@
// shared types, constants and helpers of the sensor compensation block
package sptc_pkg;

	// configuration port geometry
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	// pipeline geometry
	localparam int PRE_STAGES = 14;
	localparam int DIV_STEPS  = 64;

	// register indexes
	typedef enum logic [2:0] {
		REG_TEMP_OFFSET = 3'd0,
		REG_TEMP_CAL    = 3'd1,
		REG_PRES_LOW    = 3'd2,
		REG_PRES_HIGH   = 3'd3,
		REG_PRES_LAST   = 3'd4,
		REG_HUM_CAL     = 3'd5
	} reg_idx_t;

	// compensation constants
	localparam logic [32:0] TEMP_PRES_BASE = 33'd128000;
	localparam logic [12:0] PRES_SCALE     = 13'd3125;
	localparam logic [20:0] PRES_ADC_FULL  = 21'd1048576;
	localparam logic [31:0] TEMP_HUM_BASE  = 32'd76800;
	localparam logic [31:0] HUM_ROUND_X    = 32'd16384;
	localparam logic [21:0] HUM_W_BIAS     = 22'd32768;
	localparam logic [22:0] HUM_Y_BIAS     = 23'd2097152;
	localparam logic [31:0] HUM_ROUND_Y    = 32'd8192;
	localparam logic [31:0] HUM_CLAMP      = 32'd419430400;
	localparam logic [16:0] HUM_MAX        = HUM_CLAMP[28:12];
	localparam logic [31:0] PRES_P1_BIAS   = 32'h0000_8000;
	localparam logic [31:0] TEMP_ROUND     = 32'd128;
	localparam logic signed [24:0] TEMP_MAX = 25'sd32767;
	localparam logic signed [24:0] TEMP_MIN = -25'sd32768;

	typedef struct packed {
		logic [15:0] adc_humidity;
		logic [19:0] adc_temperature;
		logic [19:0] adc_pressure;
	} sample_t;

	typedef struct packed {
		logic        divisor_zero;
		logic [16:0] humidity_q22_10;
		logic [31:0] pressure_q24_8;
		logic signed [15:0] temperature_centi;
	} result_t;

	// decoded calibration coefficients
	typedef struct packed {
		logic signed [15:0] temp_offset;
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic        [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
		logic        [7:0]  h1;
		logic signed [15:0] h2;
		logic        [7:0]  h3;
		logic signed [11:0] h4;
		logic signed [11:0] h5;
		logic signed [7:0]  h6;
	} cfg_t;

	// results that ride alongside the divider
	typedef struct packed {
		logic signed [15:0] temp;
		logic        [16:0] hum;
	} side_t;

	typedef struct packed {
		logic [63:0] num;
		logic [30:0] den;
		logic        neg;
		logic        dz;
		side_t       side;
	} div_req_t;

	typedef struct packed {
		logic [63:0] quo;
		logic        neg;
		logic        dz;
		side_t       side;
	} div_rsp_t;

	// recombine a 64-bit wrapped product from its low and high partials
	function automatic logic [63:0] join64(input logic signed [48:0] lo, input logic [31:0] hi);
		join64 = {{15{lo[48]}}, lo} + {hi, 32'd0};
	endfunction

endpackage

@@ hw/rtl/sptc_regs.sv @@
// apb register file holding the calibration coefficients
module sptc_regs import sptc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [15:0] offset_q;
	logic [47:0] tcal_q;
	logic [63:0] plo_q;
	logic [63:0] phi_q;
	logic [15:0] plast_q;
	logic [63:0] hcal_q;
	logic        wr;
	reg_idx_t    idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[5:3]);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			tcal_q   <= '0;
			plo_q    <= '0;
			phi_q    <= '0;
			plast_q  <= '0;
			hcal_q   <= '0;
		end else if (wr) begin
			case (idx)
				REG_TEMP_OFFSET: offset_q <= pwdata[15:0];
				REG_TEMP_CAL:    tcal_q   <= pwdata[47:0];
				REG_PRES_LOW:    plo_q    <= pwdata;
				REG_PRES_HIGH:   phi_q    <= pwdata;
				REG_PRES_LAST:   plast_q  <= pwdata[15:0];
				REG_HUM_CAL:     hcal_q   <= pwdata;
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_TEMP_OFFSET: prdata = {48'd0, offset_q};
			REG_TEMP_CAL:    prdata = {16'd0, tcal_q};
			REG_PRES_LOW:    prdata = plo_q;
			REG_PRES_HIGH:   prdata = phi_q;
			REG_PRES_LAST:   prdata = {48'd0, plast_q};
			REG_HUM_CAL:     prdata = hcal_q;
			default:         prdata = '0;
		endcase
	end

	// coefficient unpacking
	assign cfg.temp_offset = offset_q;
	assign cfg.t1 = tcal_q[15:0];
	assign cfg.t2 = tcal_q[31:16];
	assign cfg.t3 = tcal_q[47:32];
	assign cfg.p1 = plo_q[15:0];
	assign cfg.p2 = plo_q[31:16];
	assign cfg.p3 = plo_q[47:32];
	assign cfg.p4 = plo_q[63:48];
	assign cfg.p5 = phi_q[15:0];
	assign cfg.p6 = phi_q[31:16];
	assign cfg.p7 = phi_q[47:32];
	assign cfg.p8 = phi_q[63:48];
	assign cfg.p9 = plast_q;
	assign cfg.h1 = hcal_q[7:0];
	assign cfg.h2 = hcal_q[23:8];
	assign cfg.h3 = hcal_q[31:24];
	assign cfg.h4 = hcal_q[43:32];
	assign cfg.h5 = hcal_q[55:44];
	assign cfg.h6 = hcal_q[63:56];

endmodule

@@ hw/rtl/sptc_pre.sv @@
// front pipeline: temperature, humidity and pressure terms up to the divide
module sptc_pre import sptc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_valid,
	input  sample_t  in_data,
	input  cfg_t     cfg,
	output logic     req_valid,
	output div_req_t req
);

	logic    vld_s [1:PRE_STAGES];
	sample_t smp_s [1:10];
	logic signed [15:0] temp_s [6:13];

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= PRE_STAGES; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= PRE_STAGES; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// sample shift line
	always_ff @(posedge clk) begin
		if (en) begin
			smp_s[1] <= in_data;
			for (int k = 2; k <= 10; k++) smp_s[k] <= smp_s[k-1];
		end
	end

	// stage 1: raw temperature differences
	logic signed [17:0] dt_c, dt_s1;
	logic signed [16:0] d_c, d_s1;
	assign dt_c = $signed({1'b0, in_data.adc_temperature[19:3]}) - $signed({1'b0, cfg.t1, 1'b0});
	assign d_c  = $signed({1'b0, in_data.adc_temperature[19:4]}) - $signed({1'b0, cfg.t1});

	// stage 2: first temperature products
	logic signed [33:0] m1_c, dd_c;
	logic [31:0] m1_s2, dd_s2;
	assign m1_c = dt_s1 * cfg.t2;
	assign dd_c = d_s1 * d_s1;

	// stage 3: scaled terms
	logic signed [19:0] dd12_c;
	logic signed [35:0] m2_c;
	logic [31:0] v1_s3, m2_s3;
	assign dd12_c = dd_s2[31:12];
	assign m2_c   = dd12_c * cfg.t3;

	// stage 4: fine temperature
	logic [31:0] tf_c, tf_s4;
	assign tf_c = v1_s3 + {{14{m2_s3[31]}}, m2_s3[31:14]};

	// stage 5: centi-degree value, humidity and pressure offsets
	logic [31:0] t5_c, hv_c, hv_s5;
	logic signed [23:0] tc_s5;
	logic signed [32:0] pa_c, pa_s5;
	assign t5_c = {tf_s4[29:0], 2'b00} + tf_s4 + TEMP_ROUND;
	assign hv_c = tf_s4 - TEMP_HUM_BASE;
	assign pa_c = $signed({tf_s4[31], tf_s4}) - $signed(TEMP_PRES_BASE);

	// stage 6: temperature saturation and first products
	logic signed [24:0] tsum_c;
	logic signed [15:0] tsat_c;
	logic signed [43:0] mh5_c;
	logic signed [39:0] mh6_c;
	logic signed [40:0] mh3_c;
	logic signed [65:0] aa_c;
	logic signed [48:0] ap5_c, ap2_c;
	logic [31:0] mh5_s6, mh6_s6, mh3_s6;
	logic [63:0] aa_s6;
	logic signed [48:0] ap5_s6, ap2_s6;
	assign tsum_c = $signed({tc_s5[23], tc_s5}) + $signed({{9{cfg.temp_offset[15]}}, cfg.temp_offset});
	always_comb begin
		if (tsum_c > TEMP_MAX) tsat_c = TEMP_MAX[15:0];
		else if (tsum_c < TEMP_MIN) tsat_c = TEMP_MIN[15:0];
		else tsat_c = tsum_c[15:0];
	end
	assign mh5_c = $signed(hv_s5) * cfg.h5;
	assign mh6_c = $signed(hv_s5) * cfg.h6;
	assign mh3_c = $signed(hv_s5) * $signed({1'b0, cfg.h3});
	assign aa_c  = pa_s5 * pa_s5;
	assign ap5_c = pa_s5 * cfg.p5;
	assign ap2_c = pa_s5 * cfg.p2;

	// stage 7: humidity x term and partial products for p6 and p3
	logic [31:0] xs_c;
	logic signed [21:0] w_c;
	logic signed [16:0] x_s7;
	logic signed [21:0] u_s7, w_s7;
	logic signed [48:0] lo6_c, lo3_c, lo6_s7, lo3_s7;
	logic signed [47:0] hi6_c, hi3_c;
	logic [31:0] hi6_s7, hi3_s7;
	logic signed [48:0] ap5_s7, ap2_s7;
	assign xs_c = {2'b00, smp_s[6].adc_humidity, 14'd0} - {cfg.h4, 20'd0} - mh5_s6 + HUM_ROUND_X;
	assign w_c  = $signed({mh3_s6[31], mh3_s6[31:11]}) + $signed(HUM_W_BIAS);
	assign lo6_c = $signed({1'b0, aa_s6[31:0]}) * cfg.p6;
	assign hi6_c = $signed(aa_s6[63:32]) * cfg.p6;
	assign lo3_c = $signed({1'b0, aa_s6[31:0]}) * cfg.p3;
	assign hi3_c = $signed(aa_s6[63:32]) * cfg.p3;

	// stage 8: humidity u*w and recombined pressure products
	logic signed [43:0] uw_c;
	logic [31:0] uw_s8;
	logic signed [16:0] x_s8;
	logic [63:0] b6_s8, a3_s8;
	logic signed [48:0] ap5_s8, ap2_s8;
	assign uw_c = u_s7 * w_s7;

	// stage 9: humidity times h2, pressure b and a terms
	logic signed [22:0] y1_c;
	logic signed [38:0] hy2_c;
	logic [31:0] hy2_s9;
	logic signed [16:0] x_s9;
	logic [63:0] b_s9, ax_s9;
	assign y1_c  = $signed({uw_s8[31], uw_s8[31:10]}) + $signed(HUM_Y_BIAS);
	assign hy2_c = y1_c * cfg.h2;

	// stage 10: humidity x*y, pressure p1 partials
	logic [31:0] yr_c;
	logic signed [17:0] ys_c;
	logic signed [34:0] hvv_c;
	logic [31:0] axh_c;
	logic [47:0] lo1_c, hi1_c;
	logic [31:0] hvv_s10;
	logic [47:0] lo1_s10;
	logic [31:0] hi1_s10;
	logic [63:0] b_s10;
	assign yr_c  = hy2_s9 + HUM_ROUND_Y;
	assign ys_c  = yr_c[31:14];
	assign hvv_c = x_s9 * ys_c;
	assign axh_c = ax_s9[63:32] + PRES_P1_BIAS;
	assign lo1_c = ax_s9[31:0] * cfg.p1;
	assign hi1_c = axh_c * cfg.p1;

	// stage 11: humidity square, divisor and dividend base
	logic signed [16:0] s_c;
	logic signed [33:0] ss_c;
	logic [63:0] prod_c, nb_c;
	logic [20:0] nmp_c;
	logic [31:0] ss_s11, hvv_s11;
	logic [30:0] den_s11;
	logic [63:0] nb_s11;
	assign s_c    = hvv_s10[31:15];
	assign ss_c   = s_c * s_c;
	assign prod_c = join64($signed({1'b0, lo1_s10}), hi1_s10);
	assign nmp_c  = PRES_ADC_FULL - {1'b0, smp_s[10].adc_pressure};
	assign nb_c   = {12'd0, nmp_c, 31'd0} - b_s10;

	// stage 12: humidity h1 term, dividend scale partials
	logic signed [33:0] sh_c;
	logic [44:0] nlo_c, nhi_c;
	logic [31:0] hsh_s12, hvv_s12;
	logic [44:0] nlo_s12;
	logic [31:0] nhi_s12;
	logic [30:0] den_s12;
	assign sh_c  = $signed(ss_s11[31:7]) * $signed({1'b0, cfg.h1});
	assign nlo_c = nb_s11[31:0] * PRES_SCALE;
	assign nhi_c = nb_s11[63:32] * PRES_SCALE;

	// stage 13: humidity clamp, dividend
	logic [31:0] hf_c;
	logic [16:0] hum_c, hum_s13;
	logic [63:0] n_s13;
	logic [30:0] den_s13;
	assign hf_c = hvv_s12 - {{4{hsh_s12[31]}}, hsh_s12[31:4]};
	always_comb begin
		if (hf_c[31]) hum_c = '0;
		else if (hf_c > HUM_CLAMP) hum_c = HUM_MAX;
		else hum_c = hf_c[28:12];
	end

	// stage 14: magnitudes and signs for the divider
	div_req_t req_s14;

	always_ff @(posedge clk) begin
		if (en) begin
			dt_s1   <= dt_c;
			d_s1    <= d_c;
			m1_s2   <= m1_c[31:0];
			dd_s2   <= dd_c[31:0];
			v1_s3   <= {{11{m1_s2[31]}}, m1_s2[31:11]};
			m2_s3   <= m2_c[31:0];
			tf_s4   <= tf_c;
			tc_s5   <= t5_c[31:8];
			hv_s5   <= hv_c;
			pa_s5   <= pa_c;
			temp_s[6] <= tsat_c;
			for (int k = 7; k <= 13; k++) temp_s[k] <= temp_s[k-1];
			mh5_s6  <= mh5_c[31:0];
			mh6_s6  <= mh6_c[31:0];
			mh3_s6  <= mh3_c[31:0];
			aa_s6   <= aa_c[63:0];
			ap5_s6  <= ap5_c;
			ap2_s6  <= ap2_c;
			x_s7    <= xs_c[31:15];
			u_s7    <= mh6_s6[31:10];
			w_s7    <= w_c;
			lo6_s7  <= lo6_c;
			lo3_s7  <= lo3_c;
			hi6_s7  <= hi6_c[31:0];
			hi3_s7  <= hi3_c[31:0];
			ap5_s7  <= ap5_s6;
			ap2_s7  <= ap2_s6;
			uw_s8   <= uw_c[31:0];
			x_s8    <= x_s7;
			b6_s8   <= join64(lo6_s7, hi6_s7);
			a3_s8   <= join64(lo3_s7, hi3_s7);
			ap5_s8  <= ap5_s7;
			ap2_s8  <= ap2_s7;
			hy2_s9  <= hy2_c[31:0];
			x_s9    <= x_s8;
			b_s9    <= b6_s8 + {ap5_s8[46:0], 17'd0} + {{13{cfg.p4[15]}}, cfg.p4, 35'd0};
			ax_s9   <= {{8{a3_s8[63]}}, a3_s8[63:8]} + {{3{ap2_s8[48]}}, ap2_s8, 12'd0};
			hvv_s10 <= hvv_c[31:0];
			lo1_s10 <= lo1_c;
			hi1_s10 <= hi1_c[31:0];
			b_s10   <= b_s9;
			ss_s11  <= ss_c[31:0];
			hvv_s11 <= hvv_s10;
			den_s11 <= prod_c[63:33];
			nb_s11  <= nb_c;
			hsh_s12 <= sh_c[31:0];
			hvv_s12 <= hvv_s11;
			nlo_s12 <= nlo_c;
			nhi_s12 <= nhi_c[31:0];
			den_s12 <= den_s11;
			hum_s13 <= hum_c;
			n_s13   <= {nhi_s12, 32'd0} + {19'd0, nlo_s12};
			den_s13 <= den_s12;
			req_s14.num  <= n_s13[63] ? (64'd0 - n_s13) : n_s13;
			req_s14.den  <= den_s13[30] ? (31'd0 - den_s13) : den_s13;
			req_s14.neg  <= n_s13[63] ^ den_s13[30];
			req_s14.dz   <= (den_s13 == '0);
			req_s14.side <= '{temp: temp_s[13], hum: hum_s13};
		end
	end

	assign req       = req_s14;
	assign req_valid = vld_s[PRE_STAGES];

endmodule

@@ hw/rtl/sptc_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module sptc_div import sptc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     req_valid,
	input  div_req_t req,
	output logic     rsp_valid,
	output div_rsp_t rsp
);

	logic        vld_s [0:DIV_STEPS-1];
	logic [30:0] rem_s [0:DIV_STEPS-1];
	logic [63:0] num_s [0:DIV_STEPS-1];
	logic [30:0] den_s [0:DIV_STEPS-1];
	logic        neg_s [0:DIV_STEPS-1];
	logic        dz_s  [0:DIV_STEPS-1];
	side_t       side_s [0:DIV_STEPS-1];

	logic [30:0] rem_in [0:DIV_STEPS-1];
	logic [63:0] num_in [0:DIV_STEPS-1];
	logic [30:0] den_in [0:DIV_STEPS-1];
	logic [30:0] rem_nx [0:DIV_STEPS-1];
	logic [63:0] num_nx [0:DIV_STEPS-1];

	// one shift-compare-subtract step per stage
	always_comb begin
		logic [31:0] trial;
		logic        ge;
		for (int j = 0; j < DIV_STEPS; j++) begin
			if (j == 0) begin
				rem_in[j] = '0;
				num_in[j] = req.num;
				den_in[j] = req.den;
			end else begin
				rem_in[j] = rem_s[j-1];
				num_in[j] = num_s[j-1];
				den_in[j] = den_s[j-1];
			end
			trial     = {rem_in[j], num_in[j][63]};
			ge        = (trial >= {1'b0, den_in[j]});
			rem_nx[j] = ge ? 31'(trial - {1'b0, den_in[j]}) : trial[30:0];
			num_nx[j] = {num_in[j][62:0], ge};
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DIV_STEPS; j++) vld_s[j] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= req_valid;
			for (int j = 1; j < DIV_STEPS; j++) vld_s[j] <= vld_s[j-1];
		end
	end

	// stage data
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < DIV_STEPS; j++) begin
				rem_s[j] <= rem_nx[j];
				num_s[j] <= num_nx[j];
				den_s[j] <= den_in[j];
			end
			neg_s[0]  <= req.neg;
			dz_s[0]   <= req.dz;
			side_s[0] <= req.side;
			for (int j = 1; j < DIV_STEPS; j++) begin
				neg_s[j]  <= neg_s[j-1];
				dz_s[j]   <= dz_s[j-1];
				side_s[j] <= side_s[j-1];
			end
		end
	end

	assign rsp_valid = vld_s[DIV_STEPS-1];
	assign rsp.quo   = num_s[DIV_STEPS-1];
	assign rsp.neg   = neg_s[DIV_STEPS-1];
	assign rsp.dz    = dz_s[DIV_STEPS-1];
	assign rsp.side  = side_s[DIV_STEPS-1];

endmodule

@@ hw/rtl/sptc_post.sv @@
// back pipeline: pressure refinement, clamping and output register
module sptc_post import sptc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     rsp_valid,
	input  div_rsp_t rsp,
	input  cfg_t     cfg,
	output logic     out_valid,
	output result_t  out_data
);

	logic  vld_s [1:8];
	logic  dz_s  [1:7];
	side_t side_s [1:7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= 8; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= rsp_valid;
			for (int k = 2; k <= 8; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// stage 2: p9*q and p8*p partials
	logic [63:0] p_s1, p_s2, p_s3, p_s4, p_s5;
	logic signed [50:0] qq_c, qq_s2, qq_s3;
	logic signed [48:0] lo9_c, lo8_c, lo9_s2, lo8_s2;
	logic signed [34:0] hi9_c;
	logic signed [47:0] hi8_c;
	logic [31:0] hi9_s2, hi8_s2;
	assign qq_c  = p_s1[63:13];
	assign lo9_c = $signed({1'b0, qq_c[31:0]}) * cfg.p9;
	assign hi9_c = $signed(qq_c[50:32]) * cfg.p9;
	assign lo8_c = $signed({1'b0, p_s1[31:0]}) * cfg.p8;
	assign hi8_c = $signed(p_s1[63:32]) * cfg.p8;

	// stage 4: (p9*q)*q partials
	logic [63:0] r_s3, b8_s3, b8_s4, b8_s5;
	logic [63:0] qx_c;
	logic [63:0] ll_c, ll_s4;
	logic [63:0] hl_c, lh_c;
	logic [31:0] hl_s4, lh_s4;
	assign qx_c = {{13{qq_s3[50]}}, qq_s3};
	assign ll_c = r_s3[31:0] * qx_c[31:0];
	assign hl_c = r_s3[63:32] * qx_c[31:0];
	assign lh_c = r_s3[31:0] * qx_c[63:32];

	// stage 5 to 7: sum, scale, offset
	logic [63:0] aq_s5, sum_s6, pp_s7;
	logic [31:0] cross_c;
	assign cross_c = hl_s4 + lh_s4;

	// output clamp
	logic [31:0] pres_c;
	always_comb begin
		if (pp_s7[63]) pres_c = '0;
		else if (pp_s7[62:32] != '0) pres_c = '1;
		else pres_c = pp_s7[31:0];
	end

	result_t res_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1   <= rsp.neg ? (64'd0 - rsp.quo) : rsp.quo;
			dz_s[1]   <= rsp.dz;
			side_s[1] <= rsp.side;
			for (int k = 2; k <= 7; k++) begin
				dz_s[k]   <= dz_s[k-1];
				side_s[k] <= side_s[k-1];
			end
			qq_s2  <= qq_c;
			lo9_s2 <= lo9_c;
			hi9_s2 <= hi9_c[31:0];
			lo8_s2 <= lo8_c;
			hi8_s2 <= hi8_c[31:0];
			p_s2   <= p_s1;
			r_s3   <= join64(lo9_s2, hi9_s2);
			b8_s3  <= join64(lo8_s2, hi8_s2);
			qq_s3  <= qq_s2;
			p_s3   <= p_s2;
			ll_s4  <= ll_c;
			hl_s4  <= hl_c[31:0];
			lh_s4  <= lh_c[31:0];
			b8_s4  <= b8_s3;
			p_s4   <= p_s3;
			aq_s5  <= ll_s4 + {cross_c, 32'd0};
			b8_s5  <= b8_s4;
			p_s5   <= p_s4;
			sum_s6 <= p_s5 + {{25{aq_s5[63]}}, aq_s5[63:25]} + {{19{b8_s5[63]}}, b8_s5[63:19]};
			pp_s7  <= {{8{sum_s6[63]}}, sum_s6[63:8]} + {{44{cfg.p7[15]}}, cfg.p7, 4'd0};
			res_s8.temperature_centi <= side_s[7].temp;
			res_s8.divisor_zero      <= dz_s[7];
			res_s8.pressure_q24_8    <= dz_s[7] ? '0 : pres_c;
			res_s8.humidity_q22_10   <= dz_s[7] ? '0 : side_s[7].hum;
		end
	end

	assign out_valid = vld_s[8];
	assign out_data  = res_s8;

endmodule

@@ hw/rtl/sensor_pth_compensation.sv @@
// top level of the temperature, pressure and humidity compensation pipeline
//
// Usage: raw sample tuples enter on the sample channel (sample_valid,
// sample_stall, sample) and compensated results leave on the result channel
// (result_valid, result_stall, result). A transfer happens on a rising edge
// where valid is high and stall is low.
// Calibration and the temperature offset are written over the apb port at
// byte address 8*index while no sample is in flight.
// A sample passes through 14 front stages, 64 divider stages (one quotient
// bit each) and 8 back stages on its way to the result channel.
// Throughput is one tuple per cycle while result_stall does not hold the
// pipeline; the divider pipeline sets the depth.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and sample_stall is raised; nothing is lost or repeated.
// Reset clears all valid bits and every calibration register to zero; the
// block accepts samples in the first cycle after reset.
// A zero pressure divisor sets divisor_zero and forces pressure and
// humidity to zero; the temperature stays valid.
module sensor_pth_compensation import sptc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  sample_t           sample,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t     cfg;
	logic     en;
	logic     req_valid;
	div_req_t req;
	logic     rsp_valid;
	div_rsp_t rsp;

	// pipeline advances unless a finished result is held back
	assign en           = !(result_valid && result_stall);
	assign sample_stall = !en;

	sptc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sptc_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sample_valid),
		.in_data   (sample),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req       (req)
	);

	sptc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.req_valid (req_valid),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	sptc_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cfg       (cfg),
		.out_valid (result_valid),
		.out_data  (result)
	);

`ifndef NO_ASSERTIONS
	// zero divisor forces pressure and humidity to zero
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.divisor_zero) |->
		(result.pressure_q24_8 == '0 && result.humidity_q22_10 == '0))
		else $error("divisor_zero result carries nonzero pressure or humidity");

	// humidity never exceeds full scale
	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.humidity_q22_10 <= HUM_MAX))
		else $error("humidity above full scale");

	// input is held back only by a blocked output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (result_valid && result_stall))
		else $error("sample stall without blocked result");

	// a held pipeline keeps the divider output in place
	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(rsp_valid) && $stable(rsp.quo)))
		else $error("divider output moved during stall");
`endif

endmodule
